### design/gsb_pkg.sv
// ----------------------------------------------------------------------------
// gsb_pkg
// Shared types, sizes and request codes of the gselect branch predictor.
// ----------------------------------------------------------------------------
package gsb_pkg;

    // Sizes of the predictor.
    localparam int TABLE_ENTRIES      = 1024;
    localparam int COUNTER_BITS       = 2;
    localparam int THREADS            = 4;
    localparam int INDEX_HISTORY_BITS = 4;

    // Fixed field widths of the request and result ports.
    localparam int KIND_W   = 3;
    localparam int THREAD_W = 2;
    localparam int PC_W     = 32;
    localparam int SNAP_W   = 10;
    localparam int SHIFT_W  = 2;

    // Index width is floor(log2(TABLE_ENTRIES)); history registers share it.
    localparam int IDX_W     = $clog2(TABLE_ENTRIES + 1) - 1;
    localparam int TBL_DEPTH = 2 ** IDX_W;
    localparam int CTR_W     = COUNTER_BITS;

    // History bits and PC bits that make up the gselect index.
    localparam int HIST_IDX_BITS = (INDEX_HISTORY_BITS > IDX_W) ? IDX_W : INDEX_HISTORY_BITS;
    localparam int PC_IDX_BITS   = IDX_W - HIST_IDX_BITS;
    localparam logic [31:0] HIST_SEL_MASK = (32'd1 << HIST_IDX_BITS) - 32'd1;
    localparam logic [31:0] PC_SEL_MASK   = (32'd1 << PC_IDX_BITS) - 32'd1;

    // One history slot for every code of the thread field.
    localparam int THREAD_SLOTS = 2 ** THREAD_W;

    // Reset value of the PC shift register.
    localparam logic [SHIFT_W-1:0] PC_SHIFT_RESET = 2'd2;

    // Request kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOOKUP      = 3'd0,
        KIND_UNCOND      = 3'd1,
        KIND_RESOLVE     = 3'd2,
        KIND_SQ_RESOLVE  = 3'd3,
        KIND_SQ_RESTORE  = 3'd4,
        KIND_BTB_MISS    = 3'd5
    } kind_t;

    // Controller states.
    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_UPDATE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic read;
        logic update;
        logic clear;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic clear_last;
    } status_t;

endpackage

### design/gsb_ctrl.sv
// ----------------------------------------------------------------------------
// gsb_ctrl
// Controller of the predictor: table clearing pass, request capture and
// the read and update steps of each request.
// ----------------------------------------------------------------------------
module gsb_ctrl
    import gsb_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:
            begin
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Output logic.
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear = 1'b1;
            end
            ST_IDLE:
            begin
                busy        = 1'b0;
                cmd.capture = start;
            end
            ST_READ:
            begin
                cmd.read = 1'b1;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
            end
            default:
            begin
                busy = 1'b1;
            end
        endcase
    end

endmodule

### design/gsb_datapath.sv
// ----------------------------------------------------------------------------
// gsb_datapath
// Datapath of the predictor: request registers, per-thread history,
// counter table with its clearing sweep, and the result registers.
// ----------------------------------------------------------------------------
module gsb_datapath
    import gsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    output status_t             status,
    input  logic [KIND_W-1:0]   kind,
    input  logic [THREAD_W-1:0] thread,
    input  logic [PC_W-1:0]     branch_pc,
    input  logic                taken,
    input  logic [SNAP_W-1:0]   saved_history,
    input  logic                cfg_we,
    input  logic [SHIFT_W-1:0]  cfg_wdata,
    output logic                done,
    output logic                prediction,
    output logic [SNAP_W-1:0]   history_snapshot
);

    // Captured request.
    logic [KIND_W-1:0]   kind_reg;
    logic [THREAD_W-1:0] thread_reg;
    logic [PC_W-1:0]     pc_reg;
    logic                taken_reg;
    logic [SNAP_W-1:0]   saved_reg;
    logic [IDX_W-1:0]    before_reg;
    logic                thread_ok_reg;

    // Architectural state.
    logic [SHIFT_W-1:0]  pc_shift_reg;
    logic [IDX_W-1:0]    history_reg [THREAD_SLOTS];
    logic [IDX_W-1:0]    clr_addr_reg;
    logic [CTR_W-1:0]    table_mem [TBL_DEPTH];
    logic [CTR_W-1:0]    rdata_reg;

    // Results.
    logic                done_reg;
    logic                prediction_reg;
    logic [SNAP_W-1:0]   snapshot_reg;

    logic                thread_ok;
    logic [IDX_W-1:0]    idx_hist;
    logic [31:0]         pc_shifted;
    logic [IDX_W-1:0]    idx;
    logic                ctr_we;
    logic                mem_we;
    logic [IDX_W-1:0]    mem_waddr;
    logic [CTR_W-1:0]    mem_wdata;
    logic [CTR_W-1:0]    ctr_new;
    logic                pred;
    logic                hist_we;
    logic [IDX_W-1:0]    hist_new;

    assign thread_ok = (32'(thread) < 32'(THREADS));

    // Request capture on an input transfer.
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg      <= kind;
            thread_reg    <= thread;
            pc_reg        <= branch_pc;
            taken_reg     <= taken;
            saved_reg     <= saved_history;
            thread_ok_reg <= thread_ok;
            before_reg    <= thread_ok ? history_reg[thread] : '0;
        end
    end

    // Configuration register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_shift_reg <= PC_SHIFT_RESET;
        end
        else if (cfg_we)
        begin
            pc_shift_reg <= cfg_wdata;
        end
    end

    // Table index: low history bits above the shifted PC bits.
    assign idx_hist   = (kind_reg == KIND_RESOLVE) ? IDX_W'(saved_reg) : before_reg;
    assign pc_shifted = pc_reg >> pc_shift_reg;
    assign idx = IDX_W'(((32'(idx_hist) & HIST_SEL_MASK) << PC_IDX_BITS)
                        | (pc_shifted & PC_SEL_MASK));

    // Saturating counter step for a resolve update.
    always_comb
    begin
        ctr_new = rdata_reg;
        if (taken_reg)
        begin
            if (rdata_reg != {CTR_W{1'b1}})
            begin
                ctr_new = rdata_reg + CTR_W'(1);
            end
        end
        else if (rdata_reg != '0)
        begin
            ctr_new = rdata_reg - CTR_W'(1);
        end
    end

    // Per-kind effect of the update step.
    always_comb
    begin
        pred     = 1'b0;
        hist_we  = 1'b0;
        hist_new = before_reg;
        ctr_we   = 1'b0;
        case (kind_reg)
            KIND_LOOKUP:
            begin
                pred     = rdata_reg[CTR_W-1];
                hist_we  = 1'b1;
                hist_new = IDX_W'({before_reg, rdata_reg[CTR_W-1]});
            end
            KIND_UNCOND:
            begin
                pred     = 1'b1;
                hist_we  = 1'b1;
                hist_new = IDX_W'({before_reg, 1'b1});
            end
            KIND_RESOLVE:
            begin
                ctr_we = 1'b1;
            end
            KIND_SQ_RESOLVE:
            begin
                hist_we  = 1'b1;
                hist_new = IDX_W'({saved_reg, taken_reg});
            end
            KIND_SQ_RESTORE:
            begin
                hist_we  = 1'b1;
                hist_new = IDX_W'(saved_reg);
            end
            KIND_BTB_MISS:
            begin
                hist_we  = 1'b1;
                hist_new = before_reg & ~IDX_W'(1);
            end
            default:
            begin
                pred = 1'b0;
            end
        endcase
    end

    // History registers, written at the end of the update step.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < THREAD_SLOTS; i++)
            begin
                history_reg[i] <= '0;
            end
        end
        else if (cmd.update && hist_we && thread_ok_reg)
        begin
            history_reg[thread_reg] <= hist_new;
        end
    end

    // Clearing sweep address.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg <= '0;
        end
        else if (cmd.clear)
        begin
            clr_addr_reg <= clr_addr_reg + IDX_W'(1);
        end
    end

    assign status.clear_last = (clr_addr_reg == {IDX_W{1'b1}});

    // Table write port: clearing sweep or counter update.
    always_comb
    begin
        if (cmd.clear)
        begin
            mem_we    = 1'b1;
            mem_waddr = clr_addr_reg;
            mem_wdata = '0;
        end
        else
        begin
            mem_we    = cmd.update && ctr_we && thread_ok_reg;
            mem_waddr = idx;
            mem_wdata = ctr_new;
        end
    end

    // Counter table with registered read.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            table_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.read)
        begin
            rdata_reg <= table_mem[idx];
        end
    end

    // Result strobe.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.update;
        end
    end

    // Result payload.
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            prediction_reg <= thread_ok_reg & pred;
            snapshot_reg   <= SNAP_W'(before_reg);
        end
    end

    assign done             = done_reg;
    assign prediction       = prediction_reg;
    assign history_snapshot = snapshot_reg;

endmodule

### design/gselect_branch_predictor.sv
// ----------------------------------------------------------------------------
// gselect_branch_predictor
// Gselect direction predictor with per-thread global history.
// ----------------------------------------------------------------------------
// A request is transferred at a rising edge where start is high and busy is
// low. Its fields are kind, thread, branch_pc, taken and saved_history.
// Every request gives exactly one result: prediction and history_snapshot,
// marked by done for one cycle. The receiver cannot stall; results are
// simply presented and must be taken.
// Busy is high while a transferred request is read and updated, so the block
// takes no new request before it is through with the last one. The three
// steps are capture, counter table read and counter read-modify-write with
// history update. The PC shift register is written through cfg_we and
// cfg_wdata; the user must write it only while idle, the block itself does
// not enforce this. After reset every history register is zero, the PC
// shift is 2, and the counter table is cleared by a sweep of one entry per
// cycle over all 1024 entries, during which busy stays high.
// ----------------------------------------------------------------------------
module gselect_branch_predictor
    import gsb_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [KIND_W-1:0]   kind,
    input  logic [THREAD_W-1:0] thread,
    input  logic [PC_W-1:0]     branch_pc,
    input  logic                taken,
    input  logic [SNAP_W-1:0]   saved_history,
    input  logic                cfg_we,
    input  logic [SHIFT_W-1:0]  cfg_wdata,
    output logic                done,
    output logic                prediction,
    output logic [SNAP_W-1:0]   history_snapshot
);

    cmd_t    cmd;
    status_t status;

    // Sequencer.
    gsb_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    // History, counter table and results.
    gsb_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .status           (status),
        .kind             (kind),
        .thread           (thread),
        .branch_pc        (branch_pc),
        .taken            (taken),
        .saved_history    (saved_history),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .prediction       (prediction),
        .history_snapshot (history_snapshot)
    );

endmodule

### verif/tb_gselect_branch_predictor.sv
// ----------------------------------------------------------------------------
// tb_gselect_branch_predictor
// Self-checking testbench for the gselect branch predictor. A queue of branch
// requests feeds a driver; every transferred request is run through a local
// model of the history registers and counter table, and each result strobe
// is checked field by field against the oldest predicted result.
// ----------------------------------------------------------------------------
module tb_gselect_branch_predictor;
    import gsb_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Codes of the kind field that the block does not decode.
    localparam logic [KIND_W-1:0] KIND_SPARE_A = 3'd6;
    localparam logic [KIND_W-1:0] KIND_SPARE_B = 3'd7;

    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT = 5000;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [THREAD_W-1:0] thread;
        logic [PC_W-1:0]     pc;
        logic                taken;
        logic [SNAP_W-1:0]   saved;
    } branch_req_t;

    typedef struct {
        logic              prediction;
        logic [SNAP_W-1:0] snapshot;
    } branch_res_t;

    // Block ports.
    logic                clk           = 1'b0;
    logic                rst_n         = 1'b0;
    logic                start         = 1'b0;
    logic                busy;
    logic [KIND_W-1:0]   kind          = '0;
    logic [THREAD_W-1:0] thread        = '0;
    logic [PC_W-1:0]     branch_pc     = '0;
    logic                taken         = 1'b0;
    logic [SNAP_W-1:0]   saved_history = '0;
    logic                cfg_we        = 1'b0;
    logic [SHIFT_W-1:0]  cfg_wdata     = '0;
    logic                done;
    logic                prediction;
    logic [SNAP_W-1:0]   history_snapshot;

    // Local copy of the predictor state.
    logic [IDX_W-1:0]   model_history [THREAD_SLOTS];
    logic [CTR_W-1:0]   model_counters [TBL_DEPTH];
    logic [SHIFT_W-1:0] model_pc_shift;

    branch_req_t pending_requests [$];
    branch_res_t expected_results [$];
    branch_req_t active_req;
    int          sender_idle_pct = 0;
    int          mismatches = 0;
    int          stall_cycles = 0;

    gselect_branch_predictor dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .kind             (kind),
        .thread           (thread),
        .branch_pc        (branch_pc),
        .taken            (taken),
        .saved_history    (saved_history),
        .cfg_we           (cfg_we),
        .cfg_wdata        (cfg_wdata),
        .done             (done),
        .prediction       (prediction),
        .history_snapshot (history_snapshot)
    );

    initial
    begin
        forever #4 clk = ~clk;
    end

    // Gselect index: low history bits on top, shifted PC bits below.
    function automatic logic [IDX_W-1:0] counter_index(input logic [IDX_W-1:0] hist,
                                                       input logic [PC_W-1:0] pc);
        logic [31:0] hist_bits;
        logic [31:0] pc_bits;
        logic [31:0] idx;
        hist_bits = 32'(hist);
        pc_bits   = pc >> model_pc_shift;
        idx = ((hist_bits & HIST_SEL_MASK) << PC_IDX_BITS) | (pc_bits & PC_SEL_MASK);
        return idx[IDX_W-1:0];
    endfunction

    // Applies one request to the model and returns the result it produces.
    function automatic branch_res_t predict_result(input branch_req_t r);
        branch_res_t      res;
        logic [IDX_W-1:0] prior;
        logic [IDX_W-1:0] idx;
        logic [CTR_W-1:0] ctr;
        res.prediction = 1'b0;
        res.snapshot   = '0;
        if (r.thread >= THREADS)
            return res;
        prior        = model_history[r.thread];
        res.snapshot = prior;
        case (r.kind)
            KIND_LOOKUP:
            begin
                idx = counter_index(prior, r.pc);
                res.prediction = model_counters[idx][CTR_W-1];
                model_history[r.thread] = {prior[IDX_W-2:0], res.prediction};
            end
            KIND_UNCOND:
            begin
                res.prediction = 1'b1;
                model_history[r.thread] = {prior[IDX_W-2:0], 1'b1};
            end
            KIND_RESOLVE:
            begin
                idx = counter_index(r.saved[IDX_W-1:0], r.pc);
                ctr = model_counters[idx];
                if (r.taken && ctr != '1)
                    ctr = ctr + 1'b1;
                else if (!r.taken && ctr != '0)
                    ctr = ctr - 1'b1;
                model_counters[idx] = ctr;
            end
            KIND_SQ_RESOLVE:
                model_history[r.thread] = {r.saved[IDX_W-2:0], r.taken};
            KIND_SQ_RESTORE:
                model_history[r.thread] = r.saved[IDX_W-1:0];
            KIND_BTB_MISS:
                model_history[r.thread] = {prior[IDX_W-1:1], 1'b0};
            default:
                ;
        endcase
        return res;
    endfunction

    task automatic queue_request(input logic [KIND_W-1:0] k, input logic [THREAD_W-1:0] th,
                                 input logic [PC_W-1:0] pc, input logic tk,
                                 input logic [SNAP_W-1:0] hs);
        branch_req_t r;
        r.kind   = k;
        r.thread = th;
        r.pc     = pc;
        r.taken  = tk;
        r.saved  = hs;
        pending_requests.push_back(r);
    endtask

    // Waits until every request has been transferred and answered.
    task automatic wait_drained();
        while (pending_requests.size() != 0 || expected_results.size() != 0 || start)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_pc_shift(input logic [SHIFT_W-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        model_pc_shift = value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Random traffic: mostly restore, lookup and resolve sequences over a small
    // pool of branch addresses and history patterns so counters get trained,
    // mixed with fully random requests.
    task automatic queue_traffic(input int count);
        logic [PC_W-1:0]     pcs [4];
        int                  bias [4];
        int                  made;
        int                  sel;
        int                  reps;
        logic [1:0]          pat;
        logic [THREAD_W-1:0] th;
        logic [SNAP_W-1:0]   hs;
        logic [KIND_W-1:0]   k;
        made = 0;
        foreach (pcs[i])
        begin
            pcs[i]  = $urandom;
            bias[i] = $urandom_range(100);
        end
        while (made < count)
        begin
            th  = THREAD_W'($urandom_range(THREAD_SLOTS - 1));
            sel = $urandom_range(3);
            if ($urandom_range(99) < 80)
            begin
                pat = 2'($urandom_range(3));
                hs  = SNAP_W'($urandom_range(1023));
                hs[3:0] = {pat, pat};
                queue_request(KIND_SQ_RESTORE, th, $urandom, 1'($urandom_range(1)), hs);
                queue_request(KIND_LOOKUP, th, pcs[sel], 1'($urandom_range(1)),
                              SNAP_W'($urandom_range(1023)));
                reps = $urandom_range(1, 3);
                for (int i = 0; i < reps; i++)
                    queue_request(KIND_RESOLVE, th, pcs[sel],
                                  $urandom_range(99) < bias[sel], hs);
                made += 2 + reps;
                // Occasionally disturb the history and look up again.
                case ($urandom_range(3))
                    0: queue_request(KIND_UNCOND, th, $urandom, 1'($urandom_range(1)), hs);
                    1: queue_request(KIND_SQ_RESOLVE, th, pcs[sel], 1'($urandom_range(1)), hs);
                    2: queue_request(KIND_BTB_MISS, th, $urandom, 1'($urandom_range(1)), hs);
                    default: made--;
                endcase
                queue_request(KIND_LOOKUP, th, pcs[sel], 1'($urandom_range(1)), hs);
                made += 2;
            end
            else
            begin
                k = KIND_W'($urandom_range(7));
                queue_request(k, th, $urandom, 1'($urandom_range(1)),
                              SNAP_W'($urandom_range(1023)));
                if (k != KIND_SPARE_A && k != KIND_SPARE_B)
                    made++;
            end
        end
    endtask

    // Driver: presents the next pending request and runs the model on every
    // transfer.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                expected_results.push_back(predict_result(active_req));
            if (!start || !busy)
            begin
                if (pending_requests.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    active_req = pending_requests.pop_front();
                    kind          <= active_req.kind;
                    thread        <= active_req.thread;
                    branch_pc     <= active_req.pc;
                    taken         <= active_req.taken;
                    saved_history <= active_req.saved;
                    start         <= 1'b1;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks each result strobe against the oldest expectation.
    always @(posedge clk)
    begin : check_results
        branch_res_t want;
        if (rst_n && done === 1'b1)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: result with nothing expected: prediction %0b snapshot %0d",
                         $time, prediction, history_snapshot);
                mismatches++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (prediction !== want.prediction)
                begin
                    $display("%0t: prediction mismatch: expected %0b, actual %0b",
                             $time, want.prediction, prediction);
                    mismatches++;
                end
                if (history_snapshot !== want.snapshot)
                begin
                    $display("%0t: history_snapshot mismatch: expected %0d, actual %0d",
                             $time, want.snapshot, history_snapshot);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: counts cycles with neither a request nor a result transfer.
    always @(posedge clk)
    begin
        if ((start && busy === 1'b0) || done === 1'b1)
        begin
            stall_cycles <= 0;
        end
        else
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles == STALL_LIMIT)
            begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    // Test sequence.
    initial
    begin
        model_pc_shift = PC_SHIFT_RESET;
        foreach (model_history[i])
            model_history[i] = '0;
        foreach (model_counters[i])
            model_counters[i] = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part with the reset PC shift.
        queue_request(KIND_LOOKUP, 2'd0, 32'h0000_0000, 1'b0, 10'd0);
        // Decrement at zero must saturate, then four increments saturate high.
        queue_request(KIND_RESOLVE, 2'd0, 32'h0000_0040, 1'b0, 10'd0);
        repeat (4) queue_request(KIND_RESOLVE, 2'd0, 32'h0000_0040, 1'b1, 10'd0);
        queue_request(KIND_SQ_RESTORE, 2'd0, 32'h0000_0000, 1'b0, 10'd0);
        queue_request(KIND_LOOKUP, 2'd0, 32'h0000_0040, 1'b0, 10'd0);
        queue_request(KIND_UNCOND, 2'd3, 32'hFFFF_FFFF, 1'b0, 10'd0);
        // Squashed resolve with all ones drops the oldest bit.
        queue_request(KIND_SQ_RESOLVE, 2'd3, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_BTB_MISS, 2'd3, 32'h0000_0000, 1'b1, 10'd1023);
        queue_request(KIND_SQ_RESTORE, 2'd2, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_LOOKUP, 2'd2, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_SQ_RESOLVE, 2'd1, 32'h0000_0000, 1'b0, 10'd0);
        queue_request(KIND_RESOLVE, 2'd1, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_RESOLVE, 2'd1, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_SQ_RESTORE, 2'd1, 32'h0000_0000, 1'b0, 10'd1023);
        queue_request(KIND_LOOKUP, 2'd1, 32'hFFFF_FFFF, 1'b0, 10'd0);
        // Undecoded kinds leave all state alone.
        queue_request(KIND_SPARE_A, 2'd1, 32'hFFFF_FFFF, 1'b1, 10'd1023);
        queue_request(KIND_SPARE_B, 2'd2, 32'h0000_0000, 1'b0, 10'd0);
        queue_request(KIND_RESOLVE, 2'd0, 32'h0000_0040, 1'b0, 10'd0);
        queue_request(KIND_SQ_RESTORE, 2'd0, 32'h0000_0000, 1'b0, 10'd0);
        queue_request(KIND_LOOKUP, 2'd0, 32'h0000_0040, 1'b0, 10'd0);
        wait_drained();

        // Random phases, each at a different PC shift and idle rate.
        write_pc_shift(2'd0);
        sender_idle_pct = 27;
        queue_traffic(130);
        wait_drained();

        write_pc_shift(2'd3);
        sender_idle_pct = 64;
        queue_traffic(130);
        wait_drained();

        write_pc_shift(2'd1);
        sender_idle_pct = 0;
        queue_traffic(140);
        wait_drained();

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
